[rtl/weighted_3x3_height_smoother_unit_macros.svh]
`ifndef WEIGHTED_3X3_HEIGHT_SMOOTHER_UNIT_MACROS_SVH
`define WEIGHTED_3X3_HEIGHT_SMOOTHER_UNIT_MACROS_SVH

// same-cycle check, sampled on clk, off while rst_n is low
`define W3HS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check, sampled on clk, off while rst_n is low
`define W3HS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wt3hs_pkg.sv]
`default_nettype none

package wt3hs_pkg;

  localparam int GRID_COLS_DEF = 128;
  localparam int GRID_ROWS_DEF = 128;

  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int IDX_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int PAD_W      = OUT_DATA_W - SAMPLE_W - 2 * IDX_W;

  localparam int NUM_CELLS  = 3;
  localparam int CENTER_CELL = 1;

  // sample x zero-extended weight, then sums of three and of nine
  localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 1;
  localparam int COL_SUM_W  = PROD_W + 2;
  localparam int ACC_W      = COL_SUM_W + 2;
  localparam int FRAC_SHIFT = 15;
  localparam int ROUND_HALF = 2 ** (FRAC_SHIFT - 1);
  localparam int Q_W        = ACC_W - FRAC_SHIFT;

  localparam logic [WEIGHT_W-1:0] SELF_W_RST = 16'd8192;
  localparam logic [WEIGHT_W-1:0] SIDE_W_RST = 16'd4096;
  localparam logic [WEIGHT_W-1:0] DIAG_W_RST = 16'd2048;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_W = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one column of the 3x3 window
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } col_t;

  // per-stage advance strobes shared by all cells
  typedef struct packed {
    logic shift;
    logic mul;
    logic add;
  } stage_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic             zero;
  } meta_t;

endpackage

`default_nettype wire

[rtl/wt3hs_line_buf.sv]
`default_nettype none

module wt3hs_line_buf #(
  parameter int GRID_COLS = wt3hs_pkg::GRID_COLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(GRID_COLS+1)-1:0]  addr,
  input  wire wt3hs_pkg::sample_t              wr_sample,
  output wt3hs_pkg::sample_t                   top_q,
  output wt3hs_pkg::sample_t                   mid_q
);

  localparam int DEPTH = GRID_COLS + 1;
  localparam int AW    = $clog2(DEPTH);

  wt3hs_pkg::sample_t upper_mem [DEPTH];
  wt3hs_pkg::sample_t middle_mem [DEPTH];

  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;
  wt3hs_pkg::sample_t top_q_r;
  wt3hs_pkg::sample_t mid_q_r;

  // middle row: read old value and store the new sample in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_q_r         <= upper_mem[addr];
      mid_q_r         <= middle_mem[addr];
      middle_mem[addr] <= wr_sample;
    end
  end

  // the old middle value moves up in the next cycle, once it has been read out
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      upper_mem[wr_addr_r] <= mid_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      wr_addr_r <= addr;
    end
  end

  assign top_q = top_q_r;
  assign mid_q = mid_q_r;

endmodule

`default_nettype wire

[rtl/wt3hs_cell.sv]
`default_nettype none

module wt3hs_cell (
  input  wire logic                                clk,
  input  wire wt3hs_pkg::stage_ctl_t               ctl,
  input  wire wt3hs_pkg::col_t                     col_i,
  input  wire logic [wt3hs_pkg::WEIGHT_W-1:0]      w_outer,
  input  wire logic [wt3hs_pkg::WEIGHT_W-1:0]      w_mid,
  output wt3hs_pkg::col_t                          col_o,
  output logic signed [wt3hs_pkg::COL_SUM_W-1:0]   sum_o
);

  localparam int PW = wt3hs_pkg::PROD_W;
  localparam int SW = wt3hs_pkg::COL_SUM_W;

  wt3hs_pkg::col_t col_r;

  logic signed [PW-1:0] w_outer_s;
  logic signed [PW-1:0] w_mid_s;
  logic signed [PW-1:0] p_top_nxt, p_mid_nxt, p_bot_nxt;
  logic signed [PW-1:0] p_top_r, p_mid_r, p_bot_r;
  logic signed [SW-1:0] sum_r;

  assign w_outer_s = PW'($signed({1'b0, w_outer}));
  assign w_mid_s   = PW'($signed({1'b0, w_mid}));

  assign p_top_nxt = PW'(col_r.top) * w_outer_s;
  assign p_mid_nxt = PW'(col_r.mid) * w_mid_s;
  assign p_bot_nxt = PW'(col_r.bot) * w_outer_s;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= col_i;
    end
    if (ctl.mul) begin
      p_top_r <= p_top_nxt;
      p_mid_r <= p_mid_nxt;
      p_bot_r <= p_bot_nxt;
    end
    if (ctl.add) begin
      sum_r <= SW'(p_top_r) + SW'(p_mid_r) + SW'(p_bot_r);
    end
  end

  assign col_o = col_r;
  assign sum_o = sum_r;

endmodule

`default_nettype wire

[rtl/weighted_3x3_height_smoother_unit.sv]
// channel  ports             width   fields
// in       in_tvalid/tready  16 + 1  tdata height_sample, tuser frame_start
// out      out_tvalid/tready 32 + 1  tdata smoothed_height, row, column; tlast last_of_frame
// cfg      cfg_wr_en         16      index 0 self, 1 side, 2 diag weight
//
// one sample per clock while out_tready keeps the output moving; after its
// center-completing sample is taken, a result passes the line store read, window
// shift, product, column sum and final sum/round/saturate registers
// rst_n is synchronous: clears position, stage valids and weights; line stores
// keep their contents and need no clearing pass
// in_tready drops only when every stage up to the output register holds an item
// and out_tready is low
`default_nettype none

module weighted_3x3_height_smoother_unit #(
  parameter int GRID_COLS = wt3hs_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = wt3hs_pkg::GRID_ROWS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [wt3hs_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] height_sample
  input  wire logic                                 in_tuser,   // [0] frame_start
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [wt3hs_pkg::OUT_DATA_W-1:0]          out_tdata,  // [15:0] smoothed_height,
                                                                // [22:16] row_index,
                                                                // [29:23] column_index
  output logic                                      out_tlast,  // last_of_frame
  input  wire logic                                 cfg_wr_en,
  input  wire logic [wt3hs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wt3hs_pkg::WEIGHT_W-1:0]       cfg_wdata
);

  localparam int CW    = $clog2(GRID_COLS + 1);
  localparam int RW    = $clog2(GRID_ROWS + 1);
  localparam int NC    = wt3hs_pkg::NUM_CELLS;
  localparam int IW    = wt3hs_pkg::IDX_W;
  localparam int SAW   = wt3hs_pkg::SAMPLE_W;
  localparam int AW    = wt3hs_pkg::ACC_W;
  localparam int QW    = wt3hs_pkg::Q_W;
  localparam int FS    = wt3hs_pkg::FRAC_SHIFT;
  localparam logic signed [QW-1:0] SAT_HI = QW'(2 ** (SAW - 1) - 1);
  localparam logic signed [QW-1:0] SAT_LO = QW'(-(2 ** (SAW - 1)));

  // configuration
  logic [wt3hs_pkg::WEIGHT_W-1:0] self_w_r, side_w_r, diag_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_w_r <= wt3hs_pkg::SELF_W_RST;
      side_w_r <= wt3hs_pkg::SIDE_W_RST;
      diag_w_r <= wt3hs_pkg::DIAG_W_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wt3hs_pkg::REG_SELF_W: self_w_r <= cfg_wdata;
        wt3hs_pkg::REG_SIDE_W: side_w_r <= cfg_wdata;
        wt3hs_pkg::REG_DIAG_W: diag_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic accept;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic p1_r, p2_r;
  logic adv1, adv2, adv3, adv4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_valid_r || out_tready;
  assign adv4 = v4_r && rdy5;
  assign rdy4 = !v4_r || rdy5;
  assign adv3 = v3_r && rdy4;
  assign rdy3 = !v3_r || rdy4;
  // items with no result leave the window stage without going further
  assign adv2 = v2_r && (!p2_r || rdy3);
  assign rdy2 = !v2_r || !p2_r || rdy3;
  assign adv1 = v1_r && rdy2;
  assign rdy1 = !v1_r || rdy2;

  assign in_tready = rdy1;
  assign accept    = in_tvalid && in_tready;

  // raster position
  logic [CW-1:0] col_cnt_r, col_cur;
  logic [RW-1:0] row_cnt_r, row_cur, row_m1;
  logic [CW-1:0] col_m1;
  logic          col_end, row_end, produce;

  assign col_cur = in_tuser ? '0 : col_cnt_r;
  assign row_cur = in_tuser ? '0 : row_cnt_r;
  assign col_end = (col_cur == CW'(GRID_COLS));
  assign row_end = (row_cur == RW'(GRID_ROWS));
  assign produce = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
  assign row_m1  = row_cur - RW'(1);
  assign col_m1  = col_cur - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_end ? '0 : row_cur + RW'(1);
      end else begin
        col_cnt_r <= col_cur + CW'(1);
        row_cnt_r <= row_cur;
      end
    end
  end

  // stage 1: line store read, sample and position
  wt3hs_pkg::sample_t top_q, mid_q, bot1_r;
  wt3hs_pkg::meta_t   meta1_r, meta2_r, meta3_r, meta4_r;

  wt3hs_line_buf #(
    .GRID_COLS (GRID_COLS)
  ) u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .addr      (col_cur),
    .wr_sample (in_tdata[SAW-1:0]),
    .top_q     (top_q),
    .mid_q     (mid_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (accept) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bot1_r       <= in_tdata[SAW-1:0];
      p1_r         <= produce;
      meta1_r.row  <= IW'(row_m1);
      meta1_r.col  <= IW'(col_m1);
      meta1_r.last <= row_end && col_end;
      meta1_r.zero <= 1'b0;
    end
  end

  // window chain: newest column enters cell 0
  wt3hs_pkg::stage_ctl_t ctl;
  wt3hs_pkg::col_t       col_in  [NC];
  wt3hs_pkg::col_t       col_out [NC];
  logic signed [wt3hs_pkg::COL_SUM_W-1:0] col_sum [NC];

  assign ctl.shift = adv1;
  assign ctl.mul   = adv2 && p2_r;
  assign ctl.add   = adv3;

  assign col_in[0].top = top_q;
  assign col_in[0].mid = mid_q;
  assign col_in[0].bot = bot1_r;

  genvar k;
  generate
    for (k = 0; k < NC; k++) begin : g_cells
      if (k > 0) begin : g_link
        assign col_in[k] = col_out[k-1];
      end
      wt3hs_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .col_i   (col_in[k]),
        .w_outer ((k == wt3hs_pkg::CENTER_CELL) ? side_w_r : diag_w_r),
        .w_mid   ((k == wt3hs_pkg::CENTER_CELL) ? self_w_r : side_w_r),
        .col_o   (col_out[k]),
        .sum_o   (col_sum[k])
      );
    end
  endgenerate

  // stage 2: window holds the item's full neighborhood
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv1) begin
      v2_r <= 1'b1;
    end else if (adv2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      p2_r    <= p1_r;
      meta2_r <= meta1_r;
    end
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv2 && p2_r) begin
      v3_r <= 1'b1;
    end else if (adv3) begin
      v3_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && p2_r) begin
      meta3_r.row  <= meta2_r.row;
      meta3_r.col  <= meta2_r.col;
      meta3_r.last <= meta2_r.last;
      meta3_r.zero <= (col_out[wt3hs_pkg::CENTER_CELL].mid == '0);
    end
  end

  // stage 4: column sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv3) begin
      v4_r <= 1'b1;
    end else if (adv4) begin
      v4_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      meta4_r <= meta3_r;
    end
  end

  // final sum, round half up, saturate; a zero center gives a zero result
  logic signed [AW-1:0] total;
  logic [AW-1:0]        rounded;
  logic signed [QW-1:0] q;
  logic [SAW-1:0]       res_nxt;

  assign total   = AW'(col_sum[0]) + AW'(col_sum[1]) + AW'(col_sum[2]);
  assign rounded = total + AW'(wt3hs_pkg::ROUND_HALF);
  assign q       = $signed(rounded[AW-1:FS]);

  always_comb begin
    priority if (meta4_r.zero) begin
      res_nxt = '0;
    end else if (q > SAT_HI) begin
      res_nxt = SAT_HI[SAW-1:0];
    end else if (q < SAT_LO) begin
      res_nxt = SAT_LO[SAW-1:0];
    end else begin
      res_nxt = q[SAW-1:0];
    end
  end

  // output register
  logic [SAW-1:0] out_height_r;
  logic [IW-1:0]  out_row_r, out_col_r;
  logic           out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv4) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_height_r <= res_nxt;
      out_row_r    <= meta4_r.row;
      out_col_r    <= meta4_r.col;
      out_last_r   <= meta4_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{wt3hs_pkg::PAD_W{1'b0}}, out_col_r, out_row_r, out_height_r};
  assign out_tlast  = out_last_r;

`include "weighted_3x3_height_smoother_unit_macros.svh"

  `W3HS_ASSERT_NOW(a_last_cell, out_tvalid && out_tlast,
    (out_row_r == IW'(GRID_ROWS - 1)) && (out_col_r == IW'(GRID_COLS - 1)),
    "last_of_frame on a cell other than the final interior one")

  `W3HS_ASSERT_NEXT(a_zero_center, adv4 && meta4_r.zero,
    out_height_r == '0, "zero center gave a nonzero result")

  `W3HS_ASSERT_NEXT(a_result_kept, adv2 && p2_r,
    v3_r, "result item lost leaving the window stage")

endmodule

`default_nettype wire
